// ----- design/zsma_pkg.sv -----
package zsma_pkg;

  localparam int SAMPLE_W = 24;
  localparam int COUNT_W  = 7;
  localparam int MDATA_W  = 32;

  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic emit;
  } zsma_cmd_t;

  typedef struct packed {
    logic out_busy;
  } zsma_stat_t;

endpackage

// ----- design/zsma_ctrl.sv -----
module zsma_ctrl
  import zsma_pkg::*;
#(
  parameter int WINDOW = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  zsma_stat_t stat,
  output zsma_cmd_t  cmd
);

  localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
  localparam int STEP_W = $clog2(SUM_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOAD   = 2'd1;
  localparam logic [1:0] ST_DIV    = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [STEP_W-1:0] step_cnt;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (step_cnt == LAST_STEP) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (cmd.start) begin
        step_cnt <= '0;
      end else if (cmd.step) begin
        step_cnt <= step_cnt + 1'b1;
      end
    end
  end

endmodule

// ----- design/zsma_datapath.sv -----
module zsma_datapath
  import zsma_pkg::*;
#(
  parameter int WINDOW = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [SAMPLE_W-1:0] s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [MDATA_W-1:0]  m_tdata,
  input  zsma_cmd_t           cmd,
  output zsma_stat_t          stat
);

  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);

  logic signed [SAMPLE_W-1:0] window [WINDOW];
  logic signed [SUM_W-1:0]    sum;
  logic [COUNT_W-1:0]         count;

  logic signed [SAMPLE_W-1:0] fresh;
  logic signed [SAMPLE_W-1:0] oldest;
  logic                       fresh_nz;
  logic                       oldest_nz;

  logic [SUM_W-1:0]   quo;
  logic [COUNT_W:0]   rem;
  logic [COUNT_W-1:0] divisor;
  logic               neg;
  logic [COUNT_W-1:0] count_q;

  logic [COUNT_W:0]    rem_sh;
  logic                ge;
  logic [SAMPLE_W-1:0] q_trunc;
  logic [SAMPLE_W-1:0] average;

  assign fresh     = s_tdata;
  assign oldest    = window[WINDOW-1];
  assign fresh_nz  = (fresh != '0);
  assign oldest_nz = (oldest != '0);

  assign rem_sh  = {rem[COUNT_W-1:0], quo[SUM_W-1]};
  assign ge      = (rem_sh >= {1'b0, divisor});
  assign q_trunc = quo[SAMPLE_W-1:0];
  assign average = neg ? (~q_trunc + 1'b1) : q_trunc;

  assign stat.out_busy = m_tvalid && !m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) begin
        window[i] <= '0;
      end
      sum   <= '0;
      count <= '0;
    end else if (cmd.load) begin
      for (int i = WINDOW - 1; i > 0; i--) begin
        window[i] <= window[i-1];
      end
      window[0] <= fresh;
      sum   <= sum + SUM_W'(fresh) - SUM_W'(oldest);
      count <= count + COUNT_W'(fresh_nz) - COUNT_W'(oldest_nz);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      neg     <= sum[SUM_W-1];
      quo     <= sum[SUM_W-1] ? (~sum + 1'b1) : sum;
      rem     <= '0;
      divisor <= (count == '0) ? COUNT_W'(1) : count;
      count_q <= count;
    end else if (cmd.step) begin
      rem <= ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
      quo <= {quo[SUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {{(MDATA_W - SAMPLE_W - COUNT_W){1'b0}}, count_q, average};
    end
  end

endmodule

// ----- design/zero_skipping_moving_average.sv -----
// Moving average over the last WINDOW samples that skips zero entries.
// Input stream s_*: one signed Q15.8 sample per transaction in s_tdata.
// Output stream m_*: one result per sample, the mean of the nonzero
// entries of the window (truncated toward zero) and their count.
// Zero entries are empty slots; an all-zero window gives mean 0, count 0.
// A running sum and count are updated on each accepted sample, then a
// restoring divider produces one quotient bit per cycle.
// After the input transaction the control passes through LOAD (divider
// operands loaded), DIV (a quotient of SUM_W = 24 + clog2(WINDOW) bits)
// and FINISH (result to m_*); no new sample is taken until it is done.
// s_tready is high while the block is idle, also while a finished result
// still sits in the output register. If the receiver stalls, the result
// holds on m_tdata and the next finished result waits in the divider.
// Reset (rst, synchronous, active high) clears the window to all zeros,
// the running sum and count, and drops any pending result.
module zero_skipping_moving_average
  import zsma_pkg::*;
#(
  parameter int WINDOW = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [SAMPLE_W-1:0] s_tdata,   // [23:0] sample
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [MDATA_W-1:0]  m_tdata    // [23:0] average, [30:24] counted, [31] zero
);

  zsma_cmd_t  cmd;
  zsma_stat_t stat;

  zsma_ctrl #(
    .WINDOW(WINDOW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  zsma_datapath #(
    .WINDOW(WINDOW)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .cmd     (cmd),
    .stat    (stat)
  );

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[30:24] <= COUNT_W'(WINDOW)))
    else $error("counted exceeds window length");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[30:24] == '0)) |-> (m_tdata[23:0] == '0))
    else $error("empty window gives nonzero average");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second sample taken while busy");
`endif

endmodule
